>>> hdl/cso_pkg.sv
`timescale 1ns / 1ps
package cso_pkg;

  // default buffer size in bytes
  localparam int BUFFER_BYTES_DEF = 256;
  // buffer address width: covers transfer position plus one segment
  localparam int AW = 10;
  localparam int COB_W = 11;
  localparam logic [COB_W-1:0] COB_RESET = 11'd1536;

  // host commands
  localparam logic [2:0] CMD_UPLOAD   = 3'd0;
  localparam logic [2:0] CMD_DOWNLOAD = 3'd1;
  localparam logic [2:0] CMD_RESP     = 3'd2;
  localparam logic [2:0] CMD_TIMEOUT  = 3'd3;
  localparam logic [2:0] CMD_WRITE    = 3'd4;
  localparam logic [2:0] CMD_READ     = 3'd5;

  // result status
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_ABORT   = 3'd2;
  localparam logic [2:0] ST_SIZE    = 3'd3;
  localparam logic [2:0] ST_TOGGLE  = 3'd4;
  localparam logic [2:0] ST_TIMEOUT = 3'd5;
  localparam logic [2:0] ST_SMALL   = 3'd6;
  localparam logic [2:0] ST_BADCMD  = 3'd7;

  // SDO command specifiers
  localparam logic [7:0] CS_UP_INIT = 8'h40;
  localparam logic [7:0] CS_UP_SEG  = 8'h60;
  localparam logic [7:0] CS_DN_INIT = 8'h21;
  localparam logic [7:0] CS_DN_EXP  = 8'h23;
  localparam logic [7:0] CS_ABORT   = 8'h80;

  typedef enum logic [2:0] {
    PH_IDLE, PH_UP_INIT, PH_UP_SEG, PH_DN_EXP, PH_DN_INIT, PH_DN_SEG
  } phase_t;

  typedef enum logic [2:0] {
    KD_UPLOAD, KD_DOWNLOAD, KD_RESP, KD_TIMEOUT, KD_WRITE, KD_READ, KD_BAD
  } kind_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] object_index;
    logic [7:0]  object_subindex;
    logic [8:0]  transfer_size;
    logic [63:0] rx_frame;
    logic [7:0]  buffer_address;
    logic [7:0]  buffer_byte;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [10:0] tx_id;
    logic [63:0] tx_frame;
    logic [2:0]  status;
    logic [31:0] abort_code;
    logic [7:0]  read_data;
    logic [8:0]  byte_count;
  } out_item_t;

  // classified item held in the queue
  typedef struct packed {
    kind_t       kind;
    logic [15:0] index;
    logic [7:0]  sub;
    logic [8:0]  size;
    logic [63:0] rx;
    logic [7:0]  addr;
    logic        addr_ok;
    logic [7:0]  wbyte;
  } q_item_t;

  // buffer access request: run of up to seven bytes from a base address
  typedef struct packed {
    logic [AW-1:0]   wbase;
    logic [2:0]      wn;
    logic [7:0][7:0] wdat;
    logic [AW-1:0]   rbase;
  } buf_req_t;

endpackage

>>> hdl/cso_buf.sv
`timescale 1ns / 1ps
module cso_buf import cso_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic            clk,
  input  buf_req_t        req,
  input  logic            rd_en,
  output logic [7:0][7:0] rd_q
);

  localparam int DEPTH = BUFFER_BYTES / 8;
  localparam int RW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // eight byte banks, interleaved by address bits 2..0
  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [7:0]    mem [DEPTH];
    logic [2:0]    wk, rk;
    logic [AW-1:0] wa, ra;
    logic          we;

    always_comb begin
      wk = 3'(b) - req.wbase[2:0];
      rk = 3'(b) - req.rbase[2:0];
      wa = req.wbase + AW'(wk);
      ra = req.rbase + AW'(rk);
      we = wk < req.wn;
    end

    always_ff @(posedge clk) begin
      if (we) begin
        mem[RW'(wa >> 3)] <= req.wdat[wk];
      end
      if (rd_en) begin
        rd_q[b] <= mem[RW'(ra >> 3)];
      end
    end
  end

endmodule

>>> hdl/cso_front.sv
`timescale 1ns / 1ps
module cso_front import cso_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     q_valid,
  output q_item_t  q_head,
  input  logic     q_pop
);

  q_item_t    ent_r [2];
  logic [1:0] count_r, count_nxt;
  logic       wp_r, rp_r;
  logic       push;
  q_item_t    cls;

  assign in_stall = count_r == 2'd2;
  assign push     = in_valid && !in_stall;
  assign q_valid  = count_r != 2'd0;
  assign q_head   = ent_r[rp_r];

  // classify the command; a start with an unusable size is a bad command
  always_comb begin
    cls.index   = in_data.object_index;
    cls.sub     = in_data.object_subindex;
    cls.size    = in_data.transfer_size;
    cls.rx      = in_data.rx_frame;
    cls.addr    = in_data.buffer_address;
    cls.addr_ok = int'(in_data.buffer_address) < BUFFER_BYTES;
    cls.wbyte   = in_data.buffer_byte;
    case (in_data.cmd)
      CMD_UPLOAD, CMD_DOWNLOAD: begin
        if (in_data.transfer_size == 9'd0 || int'(in_data.transfer_size) > BUFFER_BYTES) begin
          cls.kind = KD_BAD;
        end else if (in_data.cmd == CMD_UPLOAD) begin
          cls.kind = KD_UPLOAD;
        end else begin
          cls.kind = KD_DOWNLOAD;
        end
      end
      CMD_RESP:    cls.kind = KD_RESP;
      CMD_TIMEOUT: cls.kind = KD_TIMEOUT;
      CMD_WRITE:   cls.kind = KD_WRITE;
      CMD_READ:    cls.kind = KD_READ;
      default:     cls.kind = KD_BAD;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // two-entry queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= cls;
    end
  end

endmodule

>>> hdl/cso_back.sv
`timescale 1ns / 1ps
module cso_back import cso_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  q_item_t         q_head,
  output logic            q_pop,
  input  logic [COB_W-1:0] cob_id,
  output logic            out_valid,
  input  logic            out_stall,
  output out_item_t       out_data,
  output buf_req_t        buf_req,
  output logic            rd_en,
  input  logic [7:0][7:0] rd_q
);

  // transfer state
  phase_t      phase_r, phase_nxt;
  logic        toggle_r, toggle_nxt;
  logic [8:0]  done_r, done_nxt;
  logic [8:0]  total_r, total_nxt;

  // result stage
  logic        v2_r;
  logic        txv2_r, txv2_nxt;
  logic [63:0] hdr2_r, hdr2_nxt;
  logic [2:0]  st2_r, st2_nxt;
  logic [31:0] code2_r, code2_nxt;
  logic [8:0]  cnt2_r;
  logic [2:0]  rlo2_r, rlo2_nxt;
  logic [6:0]  rmask2_r, rmask2_nxt;
  logic        off4_2_r, off4_2_nxt;
  logic        rdsel2_r, rdsel2_nxt;
  logic [COB_W-1:0] id2_r;

  logic        adv, fire;
  logic [7:0]  b0;
  logic        abort_f, tog_bad, size_bad, small_f;
  logic [8:0]  left_cur, dn_done, dn_left;
  logic [2:0]  n_cur, dn_n, nseg, wseg, nexp;
  logic        dn_tog;
  logic [63:0] frame;
  logic [2:0]  pos;

  assign adv   = !v2_r || !out_stall;
  assign fire  = q_valid && adv;
  assign q_pop = fire;
  assign rd_en = adv;

  // response decode
  always_comb begin
    b0       = q_head.rx[7:0];
    abort_f  = b0 == CS_ABORT;
    tog_bad  = (b0[4] != toggle_r) && (phase_r == PH_UP_SEG || phase_r == PH_DN_SEG);
    nexp     = (total_r < 9'd4) ? total_r[2:0] : 3'd4;
    size_bad = b0[0] && (total_r != 9'(3'd4 - {1'b0, b0[3:2]}));
    small_f  = 32'(total_r) < q_head.rx[63:32];
    left_cur = total_r - done_r;
    n_cur    = (left_cur <= 9'd7) ? left_cur[2:0] : 3'd7;
    nseg     = 3'd7 - b0[3:1];
    wseg     = (left_cur < 9'(nseg)) ? left_cur[2:0] : nseg;
    // next download segment, after this response's update
    dn_done  = (phase_r == PH_DN_SEG) ? done_r + 9'(n_cur) : done_r;
    dn_tog   = (phase_r == PH_DN_SEG) ? ~toggle_r : toggle_r;
    dn_left  = total_r - dn_done;
    dn_n     = (dn_left <= 9'd7) ? dn_left[2:0] : 3'd7;
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      case (q_head.kind)
        KD_UPLOAD: begin
          if (phase_r == PH_IDLE) phase_nxt = PH_UP_INIT;
        end
        KD_DOWNLOAD: begin
          if (phase_r == PH_IDLE) begin
            phase_nxt = (q_head.size <= 9'd4) ? PH_DN_EXP : PH_DN_INIT;
          end
        end
        KD_RESP: begin
          if (phase_r != PH_IDLE) begin
            if (abort_f) begin
              phase_nxt = PH_IDLE;
            end else begin
              case (phase_r)
                PH_UP_INIT: phase_nxt = (b0[1] || small_f) ? PH_IDLE : PH_UP_SEG;
                PH_UP_SEG:  phase_nxt = (tog_bad || b0[0]) ? PH_IDLE : PH_UP_SEG;
                PH_DN_INIT: phase_nxt = PH_DN_SEG;
                PH_DN_SEG: begin
                  phase_nxt = (tog_bad || left_cur <= 9'd7) ? PH_IDLE : PH_DN_SEG;
                end
                default:    phase_nxt = PH_IDLE;
              endcase
            end
          end
        end
        KD_TIMEOUT: phase_nxt = PH_IDLE;
        default:    phase_nxt = phase_r;
      endcase
    end
  end

  // datapath, buffer access and result fields
  always_comb begin
    toggle_nxt  = toggle_r;
    done_nxt    = done_r;
    total_nxt   = total_r;
    txv2_nxt    = 1'b0;
    hdr2_nxt    = '0;
    st2_nxt     = ST_OK;
    code2_nxt   = '0;
    rlo2_nxt    = '0;
    rmask2_nxt  = '0;
    off4_2_nxt  = 1'b0;
    rdsel2_nxt  = 1'b0;
    buf_req     = '0;
    if (fire) begin
      case (q_head.kind)
        KD_UPLOAD, KD_DOWNLOAD: begin
          if (phase_r != PH_IDLE) begin
            st2_nxt = ST_BADCMD;
          end else begin
            total_nxt  = q_head.size;
            done_nxt   = '0;
            toggle_nxt = 1'b0;
            txv2_nxt   = 1'b1;
            hdr2_nxt[31:8] = {q_head.sub, q_head.index};
            if (q_head.kind == KD_UPLOAD) begin
              hdr2_nxt[7:0] = CS_UP_INIT;
            end else if (q_head.size <= 9'd4) begin
              hdr2_nxt[7:0] = CS_DN_EXP + {4'd0, 2'(3'd4 - q_head.size[2:0]), 2'd0};
              off4_2_nxt = 1'b1;
              for (int k = 0; k < 4; k++) begin
                rmask2_nxt[k] = 9'(k) < q_head.size;
              end
            end else begin
              hdr2_nxt[7:0]   = CS_DN_INIT;
              hdr2_nxt[40:32] = q_head.size;
            end
          end
        end
        KD_RESP: begin
          if (phase_r != PH_IDLE) begin
            if (abort_f) begin
              st2_nxt   = ST_ABORT;
              code2_nxt = q_head.rx[63:32];
            end else begin
              case (phase_r)
                PH_UP_INIT: begin
                  if (b0[1]) begin
                    if (size_bad) begin
                      st2_nxt = ST_SIZE;
                    end else begin
                      buf_req.wn = nexp;
                      for (int k = 0; k < 4; k++) begin
                        buf_req.wdat[k] = q_head.rx[8*(k+4) +: 8];
                      end
                      done_nxt = 9'(nexp);
                      st2_nxt  = ST_DONE;
                    end
                  end else if (small_f) begin
                    st2_nxt = ST_SMALL;
                  end else begin
                    txv2_nxt      = 1'b1;
                    hdr2_nxt[7:0] = CS_UP_SEG | {3'd0, toggle_r, 4'd0};
                  end
                end
                PH_UP_SEG: begin
                  if (tog_bad) begin
                    st2_nxt = ST_TOGGLE;
                  end else begin
                    buf_req.wbase = AW'(done_r);
                    buf_req.wn    = wseg;
                    for (int k = 0; k < 7; k++) begin
                      buf_req.wdat[k] = q_head.rx[8*(k+1) +: 8];
                    end
                    done_nxt   = done_r + 9'(wseg);
                    toggle_nxt = ~toggle_r;
                    if (b0[0]) begin
                      st2_nxt = ST_DONE;
                    end else begin
                      txv2_nxt      = 1'b1;
                      hdr2_nxt[7:0] = CS_UP_SEG | {3'd0, ~toggle_r, 4'd0};
                    end
                  end
                end
                PH_DN_EXP: begin
                  done_nxt = total_r;
                  st2_nxt  = ST_DONE;
                end
                PH_DN_INIT, PH_DN_SEG: begin
                  if (tog_bad) begin
                    st2_nxt = ST_TOGGLE;
                  end else begin
                    done_nxt   = dn_done;
                    toggle_nxt = dn_tog;
                    if (phase_r == PH_DN_SEG && left_cur <= 9'd7) begin
                      st2_nxt = ST_DONE;
                    end else begin
                      // build the next segment from the buffer
                      txv2_nxt      = 1'b1;
                      hdr2_nxt[7:0] = {3'd0, dn_tog, 3'd7 - dn_n, dn_left <= 9'd7};
                      buf_req.rbase = AW'(dn_done);
                      rlo2_nxt      = dn_done[2:0];
                      for (int k = 0; k < 7; k++) begin
                        rmask2_nxt[k] = 3'(k) < dn_n;
                      end
                    end
                  end
                end
                default: st2_nxt = ST_OK;
              endcase
            end
          end
        end
        KD_TIMEOUT: begin
          if (phase_r != PH_IDLE) st2_nxt = ST_TIMEOUT;
        end
        KD_WRITE: begin
          buf_req.wbase   = AW'(q_head.addr);
          buf_req.wn      = {2'd0, q_head.addr_ok};
          buf_req.wdat[0] = q_head.wbyte;
        end
        KD_READ: begin
          buf_req.rbase = AW'(q_head.addr);
          rlo2_nxt      = q_head.addr[2:0];
          rmask2_nxt[0] = q_head.addr_ok;
          rdsel2_nxt    = 1'b1;
        end
        default: st2_nxt = ST_BADCMD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      toggle_r <= 1'b0;
      done_r   <= '0;
      total_r  <= '0;
      v2_r     <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      toggle_r <= toggle_nxt;
      done_r   <= done_nxt;
      total_r  <= total_nxt;
      if (adv) v2_r <= fire;
    end
  end

  // result register, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (adv) begin
      txv2_r   <= txv2_nxt;
      hdr2_r   <= hdr2_nxt;
      st2_r    <= st2_nxt;
      code2_r  <= code2_nxt;
      cnt2_r   <= done_nxt;
      rlo2_r   <= rlo2_nxt;
      rmask2_r <= rmask2_nxt;
      off4_2_r <= off4_2_nxt;
      rdsel2_r <= rdsel2_nxt;
      id2_r    <= cob_id;
    end
  end

  // place buffer bytes into the frame
  always_comb begin
    frame = hdr2_r;
    pos   = '0;
    for (int k = 0; k < 7; k++) begin
      pos = 3'(k) + (off4_2_r ? 3'd4 : 3'd1);
      if (rmask2_r[k]) begin
        frame[8*pos +: 8] = rd_q[rlo2_r + 3'(k)];
      end
    end
  end

  assign out_valid           = v2_r;
  assign out_data.tx_valid   = txv2_r;
  assign out_data.tx_id      = txv2_r ? id2_r : '0;
  assign out_data.tx_frame   = txv2_r ? frame : '0;
  assign out_data.status     = st2_r;
  assign out_data.abort_code = code2_r;
  assign out_data.read_data  = (rdsel2_r && rmask2_r[0]) ? rd_q[rlo2_r] : 8'd0;
  assign out_data.byte_count = cnt2_r;

endmodule

>>> hdl/canopen_sdo_client_unit.sv
`timescale 1ns / 1ps
// CANopen SDO client, expedited and segmented transfers.
// Input channel (in_valid / in_stall / in_data): host commands - start upload,
// start download, server response, timeout, write or read of a buffer byte.
// Output channel (out_valid / out_stall / out_data): exactly one result beat
// per input beat, in order: request frame to send (if any), status, abort
// code, read byte and running byte count.
// Config port (cfg_*): request COB-ID at byte address 0; pready always high.
// An accepted beat is held in the queue and then in the result register
// before its result beat is on out_valid.
// Throughput: one beat per cycle while out_stall is low; each beat reads or
// writes up to seven buffer bytes together via eight interleaved byte banks.
// A two-entry queue separates the front decode from the execution stage, so
// input keeps flowing while a result waits; when the receiver stalls, the
// result register holds, the queue fills and in_stall rises.
// Reset (synchronous, rst_n low) returns to idle with counts cleared and the
// COB-ID at 0x600; buffer contents are undefined until written.
module canopen_sdo_client_unit import cso_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [COB_W-1:0] cob_r;
  logic             q_valid, q_pop, rd_en;
  q_item_t          q_head;
  buf_req_t         buf_req;
  logic [7:0][7:0]  rd_q;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {21'd0, cob_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cob_r <= COB_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      cob_r <= cfg_pwdata[COB_W-1:0];
    end
  end

  cso_front #(.BUFFER_BYTES(BUFFER_BYTES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  cso_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .cob_id    (cob_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .buf_req   (buf_req),
    .rd_en     (rd_en),
    .rd_q      (rd_q)
  );

  cso_buf #(.BUFFER_BYTES(BUFFER_BYTES)) u_buf (
    .clk   (clk),
    .req   (buf_req),
    .rd_en (rd_en),
    .rd_q  (rd_q)
  );

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
module tb;
  import cso_pkg::*;

  localparam int BUF_N = 256;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 1900;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  canopen_sdo_client_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // host commands waiting to be driven, and the results they should produce
  in_item_t  host_cmd_q[$];
  out_item_t sdo_result_q[$];

  int  n_items = 0;
  int  n_results = 0;
  int  n_mismatch = 0;
  int  status_seen[8];
  bit  quiet = 1'b0;

  // client state as predicted
  phase_t      ph = PH_IDLE;
  bit          tog = 1'b0;
  logic [8:0]  done_cnt = '0;
  logic [8:0]  tot = '0;
  logic [10:0] cob = COB_RESET;
  logic [15:0] oidx = '0;
  logic [7:0]  osub = '0;
  logic [7:0]  sdo_buf[BUF_N];
  bit          known[BUF_N];

  function automatic logic [63:0] sdo_header(logic [7:0] cs);
    return {32'h0, osub, oidx, cs};
  endfunction

  // next download segment from the current position
  function automatic logic [63:0] dn_segment();
    int left, n, i;
    logic [63:0] frm;
    left = int'(tot) - int'(done_cnt);
    n = (left <= 7) ? left : 7;
    frm = '0;
    frm[7:0] = {3'b000, tog, 3'(7 - n), (left <= 7) ? 1'b1 : 1'b0};
    for (i = 0; i < n; i++) frm[8*(1+i) +: 8] = sdo_buf[int'(done_cnt) + i];
    return frm;
  endfunction

  function automatic out_item_t sdo_client_predict(in_item_t it);
    out_item_t r;
    logic [7:0] b0;
    logic [63:0] frm;
    int n, i, left;
    r = '0;
    frm = '0;
    b0 = it.rx_frame[7:0];
    case (it.cmd)
      CMD_UPLOAD, CMD_DOWNLOAD: begin
        if (ph != PH_IDLE || it.transfer_size == 0 || it.transfer_size > BUF_N) begin
          r.status = ST_BADCMD;
        end else begin
          oidx = it.object_index;
          osub = it.object_subindex;
          tot = it.transfer_size;
          done_cnt = '0;
          tog = 1'b0;
          r.tx_valid = 1'b1;
          if (it.cmd == CMD_UPLOAD) begin
            frm = sdo_header(CS_UP_INIT);
            ph = PH_UP_INIT;
          end else if (tot <= 4) begin
            frm = sdo_header(CS_DN_EXP + 8'((4 - int'(tot)) << 2));
            for (i = 0; i < int'(tot); i++) frm[8*(4+i) +: 8] = sdo_buf[i];
            ph = PH_DN_EXP;
          end else begin
            frm = sdo_header(CS_DN_INIT);
            frm[63:32] = 32'(tot);
            ph = PH_DN_INIT;
          end
        end
      end
      CMD_RESP: begin
        if (ph == PH_IDLE) begin
          r.status = ST_OK;
        end else if (b0 == CS_ABORT) begin
          r.status = ST_ABORT;
          r.abort_code = it.rx_frame[63:32];
          ph = PH_IDLE;
        end else if (ph == PH_UP_INIT) begin
          if (b0[1]) begin
            n = (tot < 4) ? int'(tot) : 4;
            if (b0[0] && int'(tot) != 4 - int'(b0[3:2])) begin
              r.status = ST_SIZE;
            end else begin
              for (i = 0; i < n; i++) begin
                sdo_buf[i] = it.rx_frame[8*(4+i) +: 8];
                known[i] = 1'b1;
              end
              done_cnt = 9'(n);
              r.status = ST_DONE;
            end
            ph = PH_IDLE;
          end else if (32'(tot) < it.rx_frame[63:32]) begin
            r.status = ST_SMALL;
            ph = PH_IDLE;
          end else begin
            r.tx_valid = 1'b1;
            frm[7:0] = CS_UP_SEG | {3'b000, tog, 4'b0000};
            ph = PH_UP_SEG;
          end
        end else if (b0[4] != tog && (ph == PH_UP_SEG || ph == PH_DN_SEG)) begin
          r.status = ST_TOGGLE;
          ph = PH_IDLE;
        end else if (ph == PH_UP_SEG) begin
          n = 7 - int'(b0[3:1]);
          // data past the announced size is dropped
          for (i = 0; i < n; i++) begin
            if (done_cnt < tot) begin
              sdo_buf[done_cnt[7:0]] = it.rx_frame[8*(1+i) +: 8];
              known[done_cnt[7:0]] = 1'b1;
              done_cnt = done_cnt + 1;
            end
          end
          tog = ~tog;
          if (b0[0]) begin
            r.status = ST_DONE;
            ph = PH_IDLE;
          end else begin
            r.tx_valid = 1'b1;
            frm[7:0] = CS_UP_SEG | {3'b000, tog, 4'b0000};
          end
        end else if (ph == PH_DN_EXP) begin
          done_cnt = tot;
          r.status = ST_DONE;
          ph = PH_IDLE;
        end else if (ph == PH_DN_INIT) begin
          r.tx_valid = 1'b1;
          frm = dn_segment();
          ph = PH_DN_SEG;
        end else begin
          left = int'(tot) - int'(done_cnt);
          done_cnt = done_cnt + 9'((left <= 7) ? left : 7);
          tog = ~tog;
          if (left <= 7) begin
            r.status = ST_DONE;
            ph = PH_IDLE;
          end else begin
            r.tx_valid = 1'b1;
            frm = dn_segment();
          end
        end
      end
      CMD_TIMEOUT: begin
        if (ph != PH_IDLE) begin
          r.status = ST_TIMEOUT;
          ph = PH_IDLE;
        end
      end
      CMD_WRITE: begin
        sdo_buf[it.buffer_address] = it.buffer_byte;
        known[it.buffer_address] = 1'b1;
      end
      CMD_READ: r.read_data = sdo_buf[it.buffer_address];
      default: r.status = ST_BADCMD;
    endcase
    r.tx_frame = r.tx_valid ? frm : '0;
    r.tx_id = r.tx_valid ? cob : '0;
    r.byte_count = done_cnt;
    return r;
  endfunction

  function automatic in_item_t rand_item(logic [2:0] c);
    in_item_t it;
    it.cmd = c;
    it.object_index = 16'($urandom);
    it.object_subindex = 8'($urandom);
    it.transfer_size = 9'($urandom);
    it.rx_frame = {$urandom, $urandom};
    it.buffer_address = 8'($urandom);
    it.buffer_byte = 8'($urandom);
    return it;
  endfunction

  task automatic send(in_item_t it);
    sdo_result_q.push_back(sdo_client_predict(it));
    host_cmd_q.push_back(it);
    n_items++;
  endtask

  task automatic wr_byte(int addr);
    in_item_t it;
    it = rand_item(CMD_WRITE);
    it.buffer_address = 8'(addr);
    send(it);
  endtask

  // read back a byte, writing it first if it holds nothing yet
  task automatic rd_byte(int addr);
    in_item_t it;
    if (!known[addr]) wr_byte(addr);
    it = rand_item(CMD_READ);
    it.buffer_address = 8'(addr);
    send(it);
  endtask

  task automatic dsend(logic [2:0] c, int sz, logic [7:0] b0, logic [31:0] w);
    in_item_t it;
    it = rand_item(c);
    it.transfer_size = 9'(sz);
    it.rx_frame[7:0] = b0;
    it.rx_frame[63:32] = w;
    send(it);
  endtask

  // a well-formed server answer for the current wait
  task automatic good_response();
    in_item_t it;
    logic [7:0] b0;
    int n;
    it = rand_item(CMD_RESP);
    case (ph)
      PH_UP_INIT: begin
        if ($urandom_range(0, 9) < 4) begin
          n = (tot <= 4 && $urandom_range(0, 3) != 0) ? 4 - int'(tot) : $urandom_range(0, 3);
          b0 = {6'b010000, 1'b1, 1'($urandom)} | 8'(n << 2);
        end else begin
          b0 = 8'h41;
          it.rx_frame[63:32] = ($urandom_range(0, 9) == 0) ? $urandom
                                                            : 32'($urandom_range(0, tot));
        end
      end
      PH_UP_SEG: begin
        n = $urandom_range(0, 7);
        b0 = {3'b000, tog, 3'(n),
              (int'(done_cnt) + 7 - n >= int'(tot) || $urandom_range(0, 15) == 0)};
      end
      PH_DN_SEG: b0 = {3'b001, tog, 4'b0000};
      default: b0 = 8'h60;
    endcase
    it.rx_frame[7:0] = b0;
    send(it);
  endtask

  // commands that belong to no transfer, or that arrive at the wrong moment
  task automatic stray_cmd();
    in_item_t it;
    case ($urandom_range(0, 6))
      0: send(rand_item(3'($urandom_range(6, 7))));
      1: send(rand_item(CMD_TIMEOUT));
      2: send(rand_item(CMD_RESP));
      3: begin
        it = rand_item(3'($urandom_range(0, 1)));
        if (ph == PH_IDLE)
          it.transfer_size = ($urandom_range(0, 1) != 0) ? 9'd0 : 9'($urandom_range(257, 511));
        send(it);
      end
      4: wr_byte($urandom_range(0, BUF_N - 1));
      default: rd_byte($urandom_range(0, BUF_N - 1));
    endcase
  endtask

  task automatic run_transfer();
    in_item_t it;
    int sz, i, r;
    bit up;
    up = 1'($urandom);
    sz = ($urandom_range(0, 15) == 0) ? $urandom_range(1, BUF_N) : $urandom_range(1, 24);
    if (!up)
      for (i = 0; i < sz; i++) if (!known[i]) wr_byte(i);
    it = rand_item(up ? CMD_UPLOAD : CMD_DOWNLOAD);
    it.transfer_size = 9'(sz);
    send(it);
    while (ph != PH_IDLE) begin
      r = $urandom_range(0, 99);
      if (r < 2) send(rand_item(CMD_TIMEOUT));
      else if (r < 4) dsend(CMD_RESP, sz, CS_ABORT, $urandom);
      else if (r < 6) send(rand_item(CMD_RESP));
      else if (r < 9) stray_cmd();
      else good_response();
    end
  endtask

  task automatic cob_write(logic [10:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= 32'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cob = v;
  endtask

  task automatic drain();
    while (host_cmd_q.size() != 0 || sdo_result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // input driver: one beat per slot, with random gaps
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 19) == 0) begin
        in_gap <= $urandom_range(0, 11);
        in_valid <= 1'b0;
      end else if (host_cmd_q.size() != 0) begin
        in_data <= host_cmd_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stall bursts
  int out_gap = 0;
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (sdo_result_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected result beat: %p", out_data);
        end else begin
          want = sdo_result_q.pop_front();
          status_seen[out_data.status]++;
          if (out_data !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("result %0d mismatch:", n_results);
              $display("  tx_valid %0d/%0d tx_id %h/%h tx_frame %h/%h", want.tx_valid,
                       out_data.tx_valid, want.tx_id, out_data.tx_id, want.tx_frame,
                       out_data.tx_frame);
              $display("  status %0d/%0d abort %h/%h read %h/%h count %0d/%0d",
                       want.status, out_data.status, want.abort_code, out_data.abort_code,
                       want.read_data, out_data.read_data, want.byte_count,
                       out_data.byte_count);
            end
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 19) == 0) begin
        out_gap <= $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int seg;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: edges of the buffer, bad commands, each way a transfer ends
    wr_byte(0);
    wr_byte(BUF_N - 1);
    rd_byte(BUF_N - 1);
    send(rand_item(3'd6));
    send(rand_item(3'd7));
    send(rand_item(CMD_TIMEOUT));
    send(rand_item(CMD_RESP));
    dsend(CMD_UPLOAD, 0, 8'h00, 32'h0);
    dsend(CMD_DOWNLOAD, 511, 8'h00, 32'h0);
    dsend(CMD_DOWNLOAD, 1, 8'h00, 32'h0);
    dsend(CMD_RESP, 0, 8'h60, 32'h0);
    dsend(CMD_UPLOAD, 4, 8'h00, 32'h0);
    dsend(CMD_UPLOAD, 4, 8'h00, 32'h0);
    dsend(CMD_RESP, 0, 8'h43, $urandom);
    dsend(CMD_UPLOAD, 3, 8'h00, 32'h0);
    dsend(CMD_RESP, 0, 8'h43, $urandom);
    dsend(CMD_UPLOAD, BUF_N, 8'h00, 32'h0);
    dsend(CMD_RESP, 0, 8'h41, 32'hFFFF_FFFF);
    dsend(CMD_UPLOAD, 10, 8'h00, 32'h0);
    dsend(CMD_RESP, 0, 8'h41, 32'd10);
    dsend(CMD_RESP, 0, 8'h10, 32'h0);
    dsend(CMD_UPLOAD, 5, 8'h00, 32'h0);
    dsend(CMD_RESP, 0, 8'h41, 32'd5);
    dsend(CMD_RESP, 0, CS_ABORT, $urandom);
    dsend(CMD_UPLOAD, 2, 8'h00, 32'h0);
    send(rand_item(CMD_TIMEOUT));

    // random transfers under four request identifiers
    for (seg = 0; seg < 4; seg++) begin
      if (seg > 0) begin
        drain();
        cob_write(seg == 1 ? 11'd0 : seg == 2 ? 11'h7FF : 11'($urandom));
      end
      while (n_items < (seg + 1) * (RANDOM_ITEMS / 4)) begin
        if ($urandom_range(0, 4) == 0) stray_cmd();
        else run_transfer();
        if (n_items > RANDOM_ITEMS - 150) quiet = 1'b1;
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("%0d commands and %0d result beats; done %0d, abort %0d, toggle %0d,",
             n_items, n_results, status_seen[ST_DONE], status_seen[ST_ABORT],
             status_seen[ST_TOGGLE]);
    $display("timeout %0d, size %0d, too small %0d, bad command %0d; %0d mismatches",
             status_seen[ST_TIMEOUT], status_seen[ST_SIZE], status_seen[ST_SMALL],
             status_seen[ST_BADCMD], n_mismatch);
    if (n_mismatch == 0 && sdo_result_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
